>>> rtl/kahs_pkg.sv
package kahs_pkg;

  // averaging window
  localparam int WINDOW_LENGTH = 10;
  localparam int SAMPLE_BITS   = 10;
  localparam int PTR_W         = $clog2(WINDOW_LENGTH);
  localparam int SUM_W         = SAMPLE_BITS + $clog2(WINDOW_LENGTH);

  // average by reciprocal multiply: floor(sum * recip / 2^shift) == floor(sum / length)
  localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int AVG_RECIP_W = SUM_W + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'((2 ** AVG_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH);
  localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

  // field widths
  localparam int KNOB_W     = 10;
  localparam int OUT_W      = 16;
  localparam int LEVEL_W    = 10;
  localparam int BYTE_W     = 8;
  localparam int BYTE_SHIFT = 2;

  // hysteresis and clamp compare widths
  localparam int CMP_W  = (SAMPLE_BITS > KNOB_W) ? SAMPLE_BITS : KNOB_W;
  localparam int HYST_W = CMP_W + 2;

  // scaling arithmetic
  localparam int SCL_W     = OUT_W + 1;
  localparam int DEN_W     = KNOB_W;
  localparam int QUOT_W    = OUT_W + 1;
  localparam int P_LO_W    = SCL_W + DEN_W + 1;
  localparam int P_N_W     = SCL_W + DEN_W + 2;
  localparam int NUM_W     = P_N_W + 1;
  localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HYST_BAND,
    REG_KNOB_LOW,
    REG_KNOB_HIGH,
    REG_SIGNED_OUT_LOW,
    REG_SIGNED_OUT_HIGH,
    REG_UNSIGNED_OUT_LOW,
    REG_UNSIGNED_OUT_HIGH
  } cfg_reg_t;

endpackage

>>> rtl/kahs_window.sv
module kahs_window import kahs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   done,
  output logic [SUM_W-1:0]       sum
);

  logic [SAMPLE_BITS-1:0]   mem [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] filled;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [SAMPLE_BITS-1:0]   sample_hold;
  logic [PTR_W-1:0]         ptr;
  logic                     update;
  logic [SAMPLE_BITS-1:0]   oldest;
  logic [SUM_W-1:0]         sum_next;

  // an entry never written reads as zero
  assign oldest   = filled[ptr] ? rd_data : '0;
  assign sum_next = sum - SUM_W'(oldest) + SUM_W'(sample_hold);

  // window store: read oldest on start, overwrite it in the following cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rd_data     <= mem[ptr];
      sample_hold <= sample;
    end
    if (update) begin
      mem[ptr] <= sample_hold;
    end
  end

  // pointer, running sum and fill bits
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      ptr    <= '0;
      sum    <= '0;
      update <= 1'b0;
      done   <= 1'b0;
    end else begin
      update <= start;
      done   <= update;
      if (update) begin
        sum         <= sum_next;
        filled[ptr] <= 1'b1;
        ptr         <= (ptr == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr + 1'b1;
      end
    end
  end

endmodule

>>> rtl/kahs_div.sv
module kahs_div import kahs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic signed [QUOT_W:0]  quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [QUOT_W-1:0]    acc;
  logic [NUM_W-1:0]     mag_in;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 fits;

  // magnitude of the dividend, the sign is put back at the end
  assign mag_in = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);

  // one restoring step a cycle
  assign trial = {rem, acc[QUOT_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  // quotient truncated toward zero
  assign quotient = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  // datapath: upper dividend bits are below the divisor, so only quotient bits remain
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[NUM_W-1];
      rem <= mag_in[QUOT_W +: DEN_W];
      acc <= mag_in[QUOT_W-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc <= {acc[QUOT_W-2:0], fits};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/knob_average_hysteresis_scale.sv
// Knob averaging with directional hysteresis and linear output scaling.
// Input channel: one raw sample per item on in_valid/in_stall. Output
// channel: one result item per input item on out_valid/out_stall, carrying
// the held level, the level shifted right by two, and the level clamped to
// the knob range and mapped onto a signed and an unsigned output range.
// An item passes from acceptance to the result register through the window
// memory read-modify-write and the average multiply, the hysteresis, the
// scaling products and the numerators, the two serial dividers (a load, then
// one quotient bit a cycle, 17 bits) and the sequencer's output state. One
// item is worked on at a time and the next is accepted in the idle state that
// follows. in_stall is high while an item is in flight; the next item is
// accepted while a finished result still waits in the output register. If the
// receiver holds out_stall, the result holds and the following item stops
// just before loading its result.
// Reset (rst, synchronous) clears the window, running sum, held level and
// direction (rising), and loads the register defaults. Registers are written
// through write_enable/reg_index/write_data; the user must do so only while
// the block is idle, which the block itself does not enforce.
module knob_average_hysteresis_scale import kahs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write_enable,
  input  logic [CFG_IDX_W-1:0]    reg_index,
  input  logic [CFG_DATA_W-1:0]   write_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LEVEL_W-1:0]      level,
  output logic [BYTE_W-1:0]       level_byte,
  output logic signed [OUT_W-1:0] scaled_signed,
  output logic [OUT_W-1:0]        scaled_unsigned,
  output logic                    changed
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_HYST,
    S_PROD,
    S_NUM,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [KNOB_W-1:0]       hysteresis_band;
  logic [KNOB_W-1:0]       knob_low;
  logic [KNOB_W-1:0]       knob_high;
  logic signed [OUT_W-1:0] signed_out_low;
  logic signed [OUT_W-1:0] signed_out_high;
  logic [OUT_W-1:0]        unsigned_out_low;
  logic [OUT_W-1:0]        unsigned_out_high;

  // item state
  logic [SAMPLE_BITS-1:0]  held_level;
  logic                    falling_mode;
  logic                    changed_r;
  logic [AVG_PROD_W-1:0]   avg_prod;
  logic                    span_zero;
  logic                    span_inv;
  logic signed [P_LO_W-1:0] ps_lo;
  logic signed [P_N_W-1:0]  ps_n;
  logic signed [P_LO_W-1:0] pu_lo;
  logic signed [P_N_W-1:0]  pu_n;
  logic signed [NUM_W-1:0]  num_s;
  logic signed [NUM_W-1:0]  num_u;
  logic [DEN_W-1:0]         den;
  logic                     div_start;

  // submodule connections
  logic                     in_accept;
  logic                     win_done;
  logic [SUM_W-1:0]         win_sum;
  logic                     div_s_done;
  logic                     div_u_done;
  logic signed [QUOT_W:0]   quot_s;
  logic signed [QUOT_W:0]   quot_u;

  // hysteresis signals
  logic [SAMPLE_BITS-1:0]   avg;
  logic signed [HYST_W-1:0] avg_x;
  logic signed [HYST_W-1:0] cur_x;
  logic signed [HYST_W-1:0] band_x;
  logic [SAMPLE_BITS-1:0]   held_next;
  logic                     falling_next;
  logic                     changed_next;

  // clamp and scaling signals
  logic [CMP_W-1:0]         lvl_c;
  logic [CMP_W-1:0]         lvl_lo;
  logic [CMP_W-1:0]         lvl_cl;
  logic [DEN_W-1:0]         n_off;
  logic [DEN_W-1:0]         d_span;
  logic signed [SCL_W-1:0]  s_lo;
  logic signed [SCL_W-1:0]  s_hi;
  logic signed [SCL_W-1:0]  u_lo;
  logic signed [SCL_W-1:0]  u_hi;
  logic signed [SCL_W:0]    s_delta;
  logic signed [SCL_W:0]    u_delta;
  logic signed [DEN_W:0]    d_x;
  logic signed [DEN_W:0]    n_x;
  logic                     out_free;
  logic                     out_load;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_OUT) && out_free;

  kahs_window u_window (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept),
    .sample (sample),
    .done   (win_done),
    .sum    (win_sum)
  );

  kahs_div u_div_signed (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_s),
    .divisor  (den),
    .done     (div_s_done),
    .quotient (quot_s)
  );

  kahs_div u_div_unsigned (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_u),
    .divisor  (den),
    .done     (div_u_done),
    .quotient (quot_u)
  );

  // direction hysteresis on the window average
  always_comb begin
    avg          = avg_prod[AVG_SHIFT +: SAMPLE_BITS];
    avg_x        = $signed(HYST_W'(avg));
    cur_x        = $signed(HYST_W'(held_level));
    band_x       = $signed(HYST_W'(hysteresis_band));
    held_next    = held_level;
    falling_next = falling_mode;
    changed_next = 1'b0;
    if (!falling_mode) begin
      if (avg_x > cur_x) begin
        held_next    = avg;
        changed_next = 1'b1;
      end else if (avg_x < cur_x - band_x) begin
        held_next    = avg;
        falling_next = 1'b1;
        changed_next = 1'b1;
      end
    end else begin
      if (avg_x < cur_x) begin
        held_next    = avg;
        changed_next = 1'b1;
      end else if (avg_x > cur_x + band_x) begin
        held_next    = avg;
        falling_next = 1'b0;
        changed_next = 1'b1;
      end
    end
  end

  // clamp into the knob range, offsets for the normal (non-empty) range
  always_comb begin
    lvl_c   = CMP_W'(held_level);
    lvl_lo  = (lvl_c < CMP_W'(knob_low)) ? CMP_W'(knob_low) : lvl_c;
    lvl_cl  = (lvl_lo > CMP_W'(knob_high)) ? CMP_W'(knob_high) : lvl_lo;
    n_off   = DEN_W'(lvl_cl - CMP_W'(knob_low));
    d_span  = knob_high - knob_low;
    d_x     = $signed({1'b0, d_span});
    n_x     = $signed({1'b0, n_off});
    s_lo    = SCL_W'(signed_out_low);
    s_hi    = SCL_W'(signed_out_high);
    u_lo    = $signed({1'b0, unsigned_out_low});
    u_hi    = $signed({1'b0, unsigned_out_high});
    s_delta = (SCL_W+1)'(s_hi) - (SCL_W+1)'(s_lo);
    u_delta = (SCL_W+1)'(u_hi) - (SCL_W+1)'(u_lo);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hysteresis_band   <= '0;
      knob_low          <= '0;
      knob_high         <= KNOB_W'(1023);
      signed_out_low    <= '0;
      signed_out_high   <= OUT_W'(1023);
      unsigned_out_low  <= '0;
      unsigned_out_high <= OUT_W'(1023);
    end else if (write_enable) begin
      unique case (reg_index)
        REG_HYST_BAND:         hysteresis_band   <= write_data[KNOB_W-1:0];
        REG_KNOB_LOW:          knob_low          <= write_data[KNOB_W-1:0];
        REG_KNOB_HIGH:         knob_high         <= write_data[KNOB_W-1:0];
        REG_SIGNED_OUT_LOW:    signed_out_low    <= $signed(write_data[OUT_W-1:0]);
        REG_SIGNED_OUT_HIGH:   signed_out_high   <= $signed(write_data[OUT_W-1:0]);
        REG_UNSIGNED_OUT_LOW:  unsigned_out_low  <= write_data[OUT_W-1:0];
        REG_UNSIGNED_OUT_HIGH: unsigned_out_high <= write_data[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic stages, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_WIN && win_done) begin
      avg_prod <= AVG_PROD_W'(win_sum * AVG_RECIP);
    end
    if (state == S_PROD) begin
      ps_lo     <= s_lo * d_x;
      ps_n      <= s_delta * n_x;
      pu_lo     <= u_lo * d_x;
      pu_n      <= u_delta * n_x;
      den       <= d_span;
      span_zero <= (knob_high == knob_low);
      span_inv  <= (knob_high < knob_low);
    end
    if (state == S_NUM) begin
      num_s <= NUM_W'(ps_lo) + NUM_W'(ps_n);
      num_u <= NUM_W'(pu_lo) + NUM_W'(pu_n);
    end
  end

  // sequencer, held level and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held_level   <= '0;
      falling_mode <= 1'b0;
      changed_r    <= 1'b0;
      div_start    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      div_start <= (state == S_NUM);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_done) begin
            state <= S_HYST;
          end
        end
        S_HYST: begin
          held_level   <= held_next;
          falling_mode <= falling_next;
          changed_r    <= changed_next;
          state        <= S_PROD;
        end
        S_PROD: begin
          state <= S_NUM;
        end
        S_NUM: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_s_done && div_u_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            level           <= LEVEL_W'(held_level);
            level_byte      <= BYTE_W'(held_level >> BYTE_SHIFT);
            changed         <= changed_r;
            scaled_signed   <= span_zero ? signed_out_low :
                               span_inv  ? signed_out_high : quot_s[OUT_W-1:0];
            scaled_unsigned <= span_zero ? unsigned_out_low :
                               span_inv  ? unsigned_out_high : quot_u[OUT_W-1:0];
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  import kahs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = CFG_IDX_W'(7);
  localparam int IDLE_PERCENT = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 3000;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [BYTE_W-1:0]  level_byte;
    logic [OUT_W-1:0]   scaled_signed;
    logic [OUT_W-1:0]   scaled_unsigned;
    logic               changed;
  } knob_reading_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]    reg_index = '0;
  logic [CFG_DATA_W-1:0]   write_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SAMPLE_BITS-1:0]  sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [LEVEL_W-1:0]      level;
  logic [BYTE_W-1:0]       level_byte;
  logic signed [OUT_W-1:0] scaled_signed;
  logic [OUT_W-1:0]        scaled_unsigned;
  logic                    changed;

  knob_average_hysteresis_scale dut (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .reg_index       (reg_index),
    .write_data      (write_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .level           (level),
    .level_byte      (level_byte),
    .scaled_signed   (scaled_signed),
    .scaled_unsigned (scaled_unsigned),
    .changed         (changed)
  );

  // register copies, at their reset values
  logic [KNOB_W-1:0]       cfg_band = '0;
  logic [KNOB_W-1:0]       cfg_knob_low = '0;
  logic [KNOB_W-1:0]       cfg_knob_high = KNOB_W'(1023);
  logic signed [OUT_W-1:0] cfg_signed_low = '0;
  logic signed [OUT_W-1:0] cfg_signed_high = OUT_W'(1023);
  logic [OUT_W-1:0]        cfg_unsigned_low = '0;
  logic [OUT_W-1:0]        cfg_unsigned_high = OUT_W'(1023);

  // averaging window and hysteresis state
  logic [SAMPLE_BITS-1:0] window_taps [WINDOW_LENGTH];
  int  tap_ptr = 0;
  int  window_total = 0;
  int  held = 0;
  bit  falling = 1'b0;

  logic [SAMPLE_BITS-1:0] samples_to_send [$];
  knob_reading_t          readings_due [$];
  knob_reading_t          want;

  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit hold_armed = 1'b0;
  bit calm = 1'b0;

  initial begin
    foreach (window_taps[i]) window_taps[i] = '0;
  end

  // clamp to the knob range and map linearly, truncating toward zero
  function automatic longint map_level(int lvl, longint out_lo, longint out_hi);
    longint t, lo, hi, span, pos;
    t = lvl;
    lo = cfg_knob_low;
    hi = cfg_knob_high;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    span = hi - lo;
    pos = t - lo;
    if (span == 0) return out_lo;
    return (out_lo * span + pos * (out_hi - out_lo)) / span;
  endfunction

  // window average, hysteresis and scaling for one accepted sample
  function automatic knob_reading_t track_knob(logic [SAMPLE_BITS-1:0] raw);
    knob_reading_t r;
    int avg, cur, band;
    logic moved;
    window_total = window_total - int'(window_taps[tap_ptr]) + int'(raw);
    window_taps[tap_ptr] = raw;
    tap_ptr = (tap_ptr == WINDOW_LENGTH - 1) ? 0 : tap_ptr + 1;
    avg = window_total / WINDOW_LENGTH;
    cur = held;
    band = int'(cfg_band);
    moved = 1'b0;
    if (!falling) begin
      if (avg > cur) begin
        cur = avg;
        moved = 1'b1;
      end
      if (avg < cur - band) begin
        falling = 1'b1;
        cur = avg;
        moved = 1'b1;
      end
    end else begin
      if (avg < cur) begin
        cur = avg;
        moved = 1'b1;
      end
      if (avg > cur + band) begin
        falling = 1'b0;
        cur = avg;
        moved = 1'b1;
      end
    end
    held = cur & SAMPLE_MAX;
    r.level = LEVEL_W'(held);
    r.level_byte = BYTE_W'(held >> BYTE_SHIFT);
    r.scaled_signed = OUT_W'(map_level(held, longint'(cfg_signed_low),
                                       longint'(cfg_signed_high)));
    r.scaled_unsigned = OUT_W'(map_level(held, longint'(cfg_unsigned_low),
                                         longint'(cfg_unsigned_high)));
    r.changed = moved;
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [OUT_W-1:0] got, logic [OUT_W-1:0] exp_val);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_seen, got, exp_val);
    mismatches++;
  endtask

  // register write; only called while the block is idle
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    case (idx)
      REG_HYST_BAND:         cfg_band = data[KNOB_W-1:0];
      REG_KNOB_LOW:          cfg_knob_low = data[KNOB_W-1:0];
      REG_KNOB_HIGH:         cfg_knob_high = data[KNOB_W-1:0];
      REG_SIGNED_OUT_LOW:    cfg_signed_low = data;
      REG_SIGNED_OUT_HIGH:   cfg_signed_high = data;
      REG_UNSIGNED_OUT_LOW:  cfg_unsigned_low = data;
      REG_UNSIGNED_OUT_HIGH: cfg_unsigned_high = data;
      default: ;
    endcase
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // wait for every queued item to go out and every result to come back
  task automatic settle();
    while (samples_to_send.size() != 0 || in_valid || readings_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_run(int value, int count);
    repeat (count) samples_to_send.push_back(SAMPLE_BITS'(value));
  endtask

  function automatic logic [OUT_W-1:0] pick_out16();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return OUT_W'($urandom);
    endcase
  endfunction

  // 10-bit registers carry random junk above their width
  function automatic logic [CFG_DATA_W-1:0] knob_word(int value);
    return {6'($urandom), KNOB_W'(value)};
  endfunction

  task automatic pick_settings();
    int band, a, b, lo, hi;
    case ($urandom_range(3))
      0: band = 0;
      1: band = SAMPLE_MAX;
      2: band = $urandom_range(60);
      default: band = $urandom_range(SAMPLE_MAX);
    endcase
    a = $urandom_range(SAMPLE_MAX);
    b = $urandom_range(SAMPLE_MAX);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(4))
      0: begin
        lo = 0;
        hi = SAMPLE_MAX;
      end
      1: hi = lo;
      2: begin
        a = lo;
        lo = hi;
        hi = a;
      end
      default: ;
    endcase
    set_register(REG_HYST_BAND, knob_word(band));
    set_register(REG_KNOB_LOW, knob_word(lo));
    set_register(REG_KNOB_HIGH, knob_word(hi));
    set_register(REG_SIGNED_OUT_LOW, pick_out16());
    set_register(REG_SIGNED_OUT_HIGH, pick_out16());
    set_register(REG_UNSIGNED_OUT_LOW, pick_out16());
    set_register(REG_UNSIGNED_OUT_HIGH, pick_out16());
    set_register(REG_UNLISTED, OUT_W'($urandom));
  endtask

  // mostly steady runs with jitter so the average settles, some ramps, noise and extremes
  task automatic plan_samples(int count);
    int left, run, base, spread, v, pick, step;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(99);
      run = $urandom_range(4, 30);
      if (run > left) run = left;
      base = $urandom_range(SAMPLE_MAX);
      spread = $urandom_range(40);
      step = $urandom_range(80) - 40;
      for (int i = 0; i < run; i++) begin
        if (pick < 55)
          v = base + $urandom_range(2 * spread) - spread;
        else if (pick < 75)
          v = base + i * step;
        else if (pick < 92)
          v = $urandom_range(SAMPLE_MAX);
        else
          v = $urandom_range(1) ? SAMPLE_MAX : 0;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        samples_to_send.push_back(SAMPLE_BITS'(v));
      end
      left -= run;
    end
  endtask

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // sender: offers queued samples, holds a stalled item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) readings_due.push_back(track_knob(sample));
      if (!in_valid || !in_stall) begin
        if (samples_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_valid <= 1'b1;
          sample <= samples_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result item and drives out_stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        note_mismatch("unexpected item, level", level, '0);
      end else begin
        want = readings_due.pop_front();
        if (level !== want.level) note_mismatch("level", level, want.level);
        if (level_byte !== want.level_byte)
          note_mismatch("level_byte", level_byte, want.level_byte);
        if (scaled_signed !== want.scaled_signed)
          note_mismatch("scaled_signed", scaled_signed, want.scaled_signed);
        if (scaled_unsigned !== want.scaled_unsigned)
          note_mismatch("scaled_unsigned", scaled_unsigned, want.scaled_unsigned);
        if (changed !== want.changed) note_mismatch("changed", changed, want.changed);
      end
      results_seen++;
    end
    if (hold_armed) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[knob_average_hysteresis_scale] ERROR");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    while (rst) @(negedge clk);

    // defaults: climb on full scale, then fall back with no band
    push_run(SAMPLE_MAX, 5);
    push_run(0, 5);
    push_run(512, 2);
    settle();

    // widest band, empty knob range, extreme outputs, write past the register list
    set_register(REG_HYST_BAND, 16'hFFFF);
    set_register(REG_KNOB_LOW, 16'hFC00 | 16'd500);
    set_register(REG_KNOB_HIGH, 16'd500);
    set_register(REG_SIGNED_OUT_LOW, 16'h8000);
    set_register(REG_SIGNED_OUT_HIGH, 16'h7FFF);
    set_register(REG_UNSIGNED_OUT_LOW, 16'hFFFF);
    set_register(REG_UNSIGNED_OUT_HIGH, 16'h0000);
    set_register(REG_UNLISTED, 16'h1234);
    push_run(SAMPLE_MAX, 3);
    push_run(0, 3);
    settle();

    // inverted knob range, band back to zero
    set_register(REG_HYST_BAND, 16'h0000);
    set_register(REG_KNOB_LOW, 16'd1023);
    set_register(REG_KNOB_HIGH, 16'h0000);
    push_run(0, 3);
    push_run(SAMPLE_MAX, 3);
    settle();

    // random settings; first phase has no idling and a long receiver hold-off, phase three a hold-off too
    for (int phase = 0; phase < 6; phase++) begin
      pick_settings();
      calm = (phase == 0);
      hold_armed = (phase == 0 || phase == 3);
      plan_samples(105);
      settle();
    end
    calm = 1'b0;

    if (mismatches == 0)
      $display("[knob_average_hysteresis_scale] OK");
    else
      $display("[knob_average_hysteresis_scale] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/kahs_pkg.sv
rtl/kahs_window.sv
rtl/kahs_div.sv
rtl/knob_average_hysteresis_scale.sv
bench/testbench.sv
